### rtl/core/sws_pkg.sv
`default_nettype none

package sws_pkg;

  // Ring depth and the widths that follow from it
  localparam int unsigned DEPTH  = 256;
  localparam int unsigned SLOT_W = $clog2(DEPTH);

  // Field and register widths
  localparam int unsigned LEN_W      = 9;
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned STAT_W     = 48;
  localparam int unsigned THR_W      = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // A window total is at most DEPTH full-scale samples, so its magnitude
  // fits in forty bits; the divider produces one quotient bit per cycle.
  localparam int unsigned DIV_W     = 40;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic signed [STAT_W-1:0] ONE_Q16  = STAT_W'(65536);
  localparam logic signed [STAT_W-1:0] STAT_MAX = {1'b0, {(STAT_W-1){1'b1}}};
  localparam logic signed [STAT_W-1:0] STAT_MIN = {1'b1, {(STAT_W-1){1'b0}}};

  typedef enum logic [2:0] {
    MODE_IDENTITY = 3'd0,
    MODE_AVERAGE  = 3'd1,
    MODE_PEAK     = 3'd2,
    MODE_MAX      = 3'd3,
    MODE_MIN      = 3'd4,
    MODE_SUM      = 3'd5,
    MODE_CONV     = 3'd6
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE       = 2'd0,
    CFG_WINDOW_LEN = 2'd1,
    CFG_THRESHOLD  = 2'd2
  } cfg_idx_e;

  // Requests from the controller to the sample ring
  typedef struct packed {
    logic              clear;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_old_addr;
    logic [SLOT_W-1:0] rd_new_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
  } ring_req_t;

  // Start of a division: sign of the result, dividend magnitude, divisor
  typedef struct packed {
    logic             start;
    logic             neg;
    logic [DIV_W-1:0] mag;
    logic [LEN_W-1:0] divisor;
  } div_req_t;

  // Window length as used: anything above the ring depth saturates
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] wl);
    return (wl > LEN_W'(DEPTH)) ? LEN_W'(DEPTH) : wl;
  endfunction

endpackage

`default_nettype wire

### rtl/core/sws_if.sv
`default_nettype none

// Sample channel
interface sws_sample_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [sws_pkg::SAMPLE_W-1:0]    sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// Statistic channel
interface sws_stat_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [sws_pkg::STAT_W-1:0]      statistic;

  modport source (output valid, output statistic, input ready);
  modport sink   (input valid, input statistic, output ready);
endinterface

`default_nettype wire

### rtl/core/sws_ring.sv
`default_nettype none

module sws_ring (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sws_pkg::ring_req_t                  req_i,
  input  logic signed [sws_pkg::SAMPLE_W-1:0] wdata_i,
  output logic signed [sws_pkg::SAMPLE_W-1:0] old_data_o,
  output logic signed [sws_pkg::SAMPLE_W-1:0] new_data_o
);

  logic [sws_pkg::SAMPLE_W-1:0] mem [sws_pkg::DEPTH];
  logic [sws_pkg::DEPTH-1:0]    vld_q;
  logic [sws_pkg::SAMPLE_W-1:0] old_q;
  logic [sws_pkg::SAMPLE_W-1:0] new_q;
  logic                         old_vld_q;
  logic                         new_vld_q;

  // Sample storage with one write and two registered reads
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= wdata_i;
    end
    if (req_i.rd_en) begin
      old_q <= mem[req_i.rd_old_addr];
      new_q <= mem[req_i.rd_new_addr];
    end
  end

  // Per-entry valid bits; an entry never written since the last clear reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      old_vld_q <= 1'b0;
      new_vld_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        old_vld_q <= vld_q[req_i.rd_old_addr];
        new_vld_q <= vld_q[req_i.rd_new_addr];
      end
    end
  end

  assign old_data_o = old_vld_q ? old_q : '0;
  assign new_data_o = new_vld_q ? new_q : '0;

endmodule

`default_nettype wire

### rtl/core/sws_div.sv
`default_nettype none

module sws_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sws_pkg::div_req_t                 req_i,
  output logic                              done_o,
  output logic signed [sws_pkg::STAT_W-1:0] quot_o
);

  logic [sws_pkg::DIV_W-1:0]     dq_q;
  logic [sws_pkg::LEN_W-1:0]     rem_q;
  logic [sws_pkg::LEN_W-1:0]     dvs_q;
  logic                          neg_q;
  logic [sws_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                          busy_q;
  logic                          done_q;
  logic [sws_pkg::LEN_W:0]       trial;
  logic                          ge;
  logic [sws_pkg::LEN_W:0]       diff;
  logic [sws_pkg::STAT_W-1:0]    ext;

  // One restoring step: bring in the next dividend bit and try the subtract
  assign trial = {rem_q, dq_q[sws_pkg::DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  // Control of the bit-serial loop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= sws_pkg::DIV_CNT_W'(sws_pkg::DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == sws_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Dividend and quotient share one shift register
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dq_q  <= req_i.mag;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
      neg_q <= req_i.neg;
    end else if (busy_q) begin
      rem_q <= ge ? diff[sws_pkg::LEN_W-1:0] : trial[sws_pkg::LEN_W-1:0];
      dq_q  <= {dq_q[sws_pkg::DIV_W-2:0], ge};
    end
  end

  // Truncation toward zero: divide magnitudes, then restore the sign
  assign ext    = {{(sws_pkg::STAT_W - sws_pkg::DIV_W){1'b0}}, dq_q};
  assign quot_o = neg_q ? -ext : ext;
  assign done_o = done_q;

endmodule

`default_nettype wire

### rtl/core/sliding_window_statistic_unit.sv
// Channel     Dir  Payload                    Handshake
// sample_i    in   sample, Q16.16, 32 bits    valid/ready
// stat_o      out  statistic, Q32.16, 48 bits valid/ready
// cfg_*       in   index 2 bits, data 32 bits write enable, no wait
//
// One item at a time: accept, ring read, compute and output load, plus a
// divide step in average mode with a non-zero window, where the bit-serial
// divider produces one quotient bit per cycle over 40 bits.
// Reset is asynchronous and active low; the ring clears at once through
// per-entry valid bits, so there is no clearing pass. A stalled result waits
// in the output register while the next sample is taken and processed.
`default_nettype none

module sliding_window_statistic_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sws_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sws_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  sws_sample_if.sink                         sample_i,
  sws_stat_if.source                         stat_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_CALC = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  state_e                              state_q;
  sws_pkg::mode_e                      mode_q;
  logic [sws_pkg::LEN_W-1:0]           window_len_q;
  logic signed [sws_pkg::THR_W-1:0]    thr_q;
  logic [sws_pkg::SLOT_W-1:0]          oldest_q;
  logic [sws_pkg::SLOT_W-1:0]          newest_q;
  logic signed [sws_pkg::STAT_W-1:0]   held_q;
  logic signed [sws_pkg::STAT_W-1:0]   total_q;
  logic [sws_pkg::LEN_W-1:0]           settled_q;
  logic [sws_pkg::LEN_W-1:0]           settled_d;
  logic signed [sws_pkg::SAMPLE_W-1:0] sample_q;
  logic                                out_valid_q;
  logic signed [sws_pkg::STAT_W-1:0]   out_stat_q;

  logic                                in_acc;
  logic                                out_free;
  logic                                cfg_hit;
  logic                                cfg_clr;
  logic [sws_pkg::LEN_W-1:0]           wl_new;
  logic [sws_pkg::LEN_W-1:0]           len_new;
  logic [sws_pkg::SLOT_W-1:0]          newest_rst;
  logic [sws_pkg::LEN_W-1:0]           len;
  logic                                len_nz;
  logic [sws_pkg::SLOT_W:0]            old_inc;
  logic [sws_pkg::SLOT_W-1:0]          oldest_nxt;

  logic signed [sws_pkg::SAMPLE_W-1:0] old_data;
  logic signed [sws_pkg::SAMPLE_W-1:0] new_data;
  logic signed [sws_pkg::STAT_W-1:0]   s48;
  logic signed [sws_pkg::STAT_W-1:0]   t48;
  logic signed [sws_pkg::STAT_W-1:0]   old48;
  logic signed [sws_pkg::STAT_W-1:0]   new_total;
  logic signed [sws_pkg::STAT_W:0]     sum49;
  logic signed [sws_pkg::STAT_W-1:0]   sat_sum;
  logic signed [sws_pkg::SAMPLE_W:0]   d_new;
  logic signed [sws_pkg::SAMPLE_W:0]   d_old;
  logic [sws_pkg::SAMPLE_W:0]          abs_new;
  logic [sws_pkg::SAMPLE_W:0]          abs_old;
  logic                                near_new;
  logic                                near_old;
  logic signed [sws_pkg::STAT_W-1:0]   calc_v;
  logic                                div_go;
  logic [sws_pkg::STAT_W-1:0]          mag48;

  sws_pkg::ring_req_t                  ring_req;
  sws_pkg::div_req_t                   div_req;
  logic                                div_done;
  logic signed [sws_pkg::STAT_W-1:0]   quot;

  assign in_acc         = sample_i.valid && sample_i.ready;
  assign sample_i.ready = (state_q == ST_IDLE);
  assign out_free       = !out_valid_q || stat_o.ready;
  assign stat_o.valid     = out_valid_q;
  assign stat_o.statistic = out_stat_q;

  // Configuration decode; any recognised write clears the window state and ring
  assign cfg_hit = (cfg_idx_i == sws_pkg::CFG_MODE) ||
                   (cfg_idx_i == sws_pkg::CFG_WINDOW_LEN) ||
                   (cfg_idx_i == sws_pkg::CFG_THRESHOLD);
  assign cfg_clr = cfg_we_i && cfg_hit;
  assign wl_new  = (cfg_idx_i == sws_pkg::CFG_WINDOW_LEN) ?
                   cfg_wdata_i[sws_pkg::LEN_W-1:0] : window_len_q;
  assign len_new = sws_pkg::eff_len(wl_new);
  assign newest_rst = (len_new != '0) ? sws_pkg::SLOT_W'(len_new - 1'b1) : '0;

  // Window length in force and the ring pointer advance
  assign len        = sws_pkg::eff_len(window_len_q);
  assign len_nz     = (len != '0);
  assign old_inc    = {1'b0, oldest_q} + 1'b1;
  assign oldest_nxt = (sws_pkg::LEN_W'(old_inc) >= len) ? '0 :
                      old_inc[sws_pkg::SLOT_W-1:0];

  // Ring access: read both ends, then overwrite the oldest slot
  always_comb begin
    ring_req             = '0;
    ring_req.clear       = cfg_clr;
    ring_req.rd_en       = (state_q == ST_READ);
    ring_req.rd_old_addr = oldest_q;
    ring_req.rd_new_addr = newest_q;
    ring_req.wr_en       = (state_q == ST_CALC) && len_nz;
    ring_req.wr_addr     = oldest_q;
  end

  sws_ring u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (ring_req),
    .wdata_i    (sample_q),
    .old_data_o (old_data),
    .new_data_o (new_data)
  );

  // Widened operands and the updated window total
  assign s48       = {{(sws_pkg::STAT_W - sws_pkg::SAMPLE_W){sample_q[sws_pkg::SAMPLE_W-1]}},
                      sample_q};
  assign t48       = {{(sws_pkg::STAT_W - sws_pkg::THR_W){thr_q[sws_pkg::THR_W-1]}}, thr_q};
  assign old48     = {{(sws_pkg::STAT_W - sws_pkg::SAMPLE_W){old_data[sws_pkg::SAMPLE_W-1]}},
                      old_data};
  assign new_total = len_nz ? (total_q - old48 + s48) : total_q;

  // Running sum without a window, saturated to the output range
  assign sum49   = {held_q[sws_pkg::STAT_W-1], held_q} + {s48[sws_pkg::STAT_W-1], s48};
  assign sat_sum = (sum49[sws_pkg::STAT_W] != sum49[sws_pkg::STAT_W-1]) ?
                   (sum49[sws_pkg::STAT_W] ? sws_pkg::STAT_MIN : sws_pkg::STAT_MAX) :
                   sum49[sws_pkg::STAT_W-1:0];

  // Distances to the newest and oldest stored samples against epsilon
  assign d_new    = {sample_q[sws_pkg::SAMPLE_W-1], sample_q} -
                    {new_data[sws_pkg::SAMPLE_W-1], new_data};
  assign d_old    = {sample_q[sws_pkg::SAMPLE_W-1], sample_q} -
                    {old_data[sws_pkg::SAMPLE_W-1], old_data};
  assign abs_new  = d_new[sws_pkg::SAMPLE_W] ? -d_new : d_new;
  assign abs_old  = d_old[sws_pkg::SAMPLE_W] ? -d_old : d_old;
  assign near_new = $signed({1'b0, abs_new}) < $signed({{2{thr_q[sws_pkg::THR_W-1]}}, thr_q});
  assign near_old = $signed({1'b0, abs_old}) < $signed({{2{thr_q[sws_pkg::THR_W-1]}}, thr_q});

  // Statistic selected by mode
  always_comb begin
    calc_v    = held_q;
    settled_d = settled_q;
    case (mode_q)
      sws_pkg::MODE_IDENTITY: begin
        calc_v = s48;
      end
      sws_pkg::MODE_AVERAGE: begin
        calc_v = held_q;
      end
      sws_pkg::MODE_PEAK: begin
        calc_v = (sample_q > thr_q) ? (s48 - t48) : '0;
      end
      sws_pkg::MODE_MAX: begin
        if (s48 > held_q) calc_v = s48;
      end
      sws_pkg::MODE_MIN: begin
        if (s48 < held_q) calc_v = s48;
      end
      sws_pkg::MODE_SUM: begin
        calc_v = len_nz ? new_total : sat_sum;
      end
      sws_pkg::MODE_CONV: begin
        calc_v = '0;
        if (len_nz) begin
          if (near_new && near_old) begin
            if (settled_q < len) settled_d = settled_q + 1'b1;
            if (settled_d == len) calc_v = sws_pkg::ONE_Q16;
          end else begin
            settled_d = '0;
          end
        end
      end
      default: begin
        calc_v = held_q;
      end
    endcase
  end

  // Average over a non-empty window goes through the divider
  assign div_go = (mode_q == sws_pkg::MODE_AVERAGE) && len_nz;
  assign mag48  = new_total[sws_pkg::STAT_W-1] ? -new_total : new_total;

  always_comb begin
    div_req         = '0;
    div_req.start   = (state_q == ST_CALC) && div_go;
    div_req.neg     = new_total[sws_pkg::STAT_W-1];
    div_req.mag     = mag48[sws_pkg::DIV_W-1:0];
    div_req.divisor = len;
  end

  sws_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  // Sequencer, configuration registers and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mode_q       <= sws_pkg::MODE_IDENTITY;
      window_len_q <= '0;
      thr_q        <= '0;
      oldest_q     <= '0;
      newest_q     <= '0;
      held_q       <= '0;
      total_q      <= '0;
      settled_q    <= '0;
    end else if (cfg_clr) begin
      case (cfg_idx_i)
        sws_pkg::CFG_MODE:       mode_q <= sws_pkg::mode_e'(cfg_wdata_i[2:0]);
        sws_pkg::CFG_WINDOW_LEN: window_len_q <= cfg_wdata_i[sws_pkg::LEN_W-1:0];
        sws_pkg::CFG_THRESHOLD:  thr_q <= cfg_wdata_i[sws_pkg::THR_W-1:0];
        default: ;
      endcase
      oldest_q  <= '0;
      newest_q  <= newest_rst;
      held_q    <= '0;
      total_q   <= '0;
      settled_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) state_q <= ST_READ;
        end
        ST_READ: begin
          state_q <= ST_CALC;
        end
        ST_CALC: begin
          total_q   <= new_total;
          settled_q <= settled_d;
          if (len_nz) begin
            newest_q <= oldest_q;
            oldest_q <= oldest_nxt;
          end
          if (div_go) begin
            state_q <= ST_DIV;
          end else begin
            held_q  <= calc_v;
            state_q <= ST_OUT;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            held_q  <= quot;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Captured sample of the current transaction
  always_ff @(posedge clk_i) begin
    if (in_acc) sample_q <= sample_i.sample;
  end

  // Output register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_OUT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (stat_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_OUT) && out_free) out_stat_q <= held_q;
  end

endmodule

`default_nettype wire

### rtl/core/sws_checker.sv
`default_nettype none

module sws_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [sws_pkg::STAT_W-1:0] out_stat_i
);

  // A transaction keeps the unit busy through its ring read and compute cycles
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i ##1 !in_ready_i)
    else $error("sample accepted while previous transaction still in flight");

  // Loading a result returns the unit to idle at the same time
  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("result presented while the unit is still busy");

  // A stalled result stays presented and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_stat_i)))
    else $error("stalled result dropped or changed");

endmodule

bind sliding_window_statistic_unit sws_checker u_sws_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (stat_o.valid),
  .out_ready_i (stat_o.ready),
  .out_stat_i  (stat_o.statistic)
);

`default_nettype wire
